// ===== hw/rtl/sss_pkg.sv =====
// Package for the subrecord stream splitter.
// Holds result kinds, parser phases, header constants, result-queue sizing and shared types.
// No dependencies.
`default_nettype none

package sss_pkg;

    // Result kinds
    localparam logic [1:0] KIND_SUBREC = 2'd0;
    localparam logic [1:0] KIND_OK     = 2'd1;
    localparam logic [1:0] KIND_BAD    = 2'd2;

    // Parser phases (the unused code behaves as header)
    localparam logic [1:0] PH_HEADER   = 2'd0;
    localparam logic [1:0] PH_OVERRIDE = 2'd1;
    localparam logic [1:0] PH_PAYLOAD  = 2'd2;

    // Subrecord header constants
    localparam logic [31:0] OVERRIDE_TYPE = 32'h5858_5858;  // "XXXX"
    localparam logic [2:0]  HEADER_LEN    = 3'd6;
    localparam logic [2:0]  OVERRIDE_LEN  = 3'd4;

    // Result queue sizing (room for two results per request plus slack)
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] type_code;
        logic [31:0] data_offset;
        logic [31:0] data_size;
        logic        last_of_run;
    } t_result;

    // Results produced by one input request, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

endpackage

`default_nettype wire

// ===== hw/rtl/sss_in_if.sv =====
// Input channel of the subrecord stream splitter: one body byte per request.
// No dependencies.
`default_nettype none

interface sss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sss_out_if.sv =====
// Output channel of the subrecord stream splitter: one result per request.
// No dependencies.
`default_nettype none

interface sss_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] type_code;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic        last_of_run;

    modport source (output valid, output kind, output type_code, output data_offset,
                    output data_size, output last_of_run, input ready);
    modport sink   (input valid, input kind, input type_code, input data_offset,
                    input data_size, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/subrecord_stream_splitter.sv =====
// Top level of the subrecord stream splitter.
// Depends on sss_pkg, sss_in_if, sss_out_if, sss_parser and sss_result_fifo.
//
// Takes one record-body byte per request and splits the body into subrecords
// (4-byte type, 16-bit little-endian size, data; an XXXX subrecord of size 4
// overrides the next size with 32 bits). Each complete subrecord is reported
// with its type, data offset and size, and the final byte of a buffer always
// yields a status result (ok or malformed) with last_of_run set. A byte is
// parsed in the cycle it is accepted, so the block takes one byte per clock;
// its results are written to a four-entry queue and leave at one per clock
// while the sink is ready. The input stalls only when the queue has fewer than
// two free entries, which happens only when the sink stalls: a final byte that
// also completes a subrecord adds two results at once, but the byte before it
// never adds one, so with a ready sink the queue never holds more than two.
`default_nettype none

module subrecord_stream_splitter (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sss_in_if.sink    i_in,
    sss_out_if.source o_out
);

    sss_pkg::t_step w_step;
    logic           w_room;
    logic           w_take;

    assign i_in.ready = w_room;
    assign w_take     = i_in.valid && w_room;

    sss_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_take),
        .i_data_byte     (i_in.data_byte),
        .i_end_of_buffer (i_in.end_of_buffer),
        .o_step          (w_step)
    );

    sss_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_step  (w_step),
        .o_room  (w_room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sss_parser.sv =====
// Byte-at-a-time subrecord parser: header, size override and payload tracking.
// Depends on sss_pkg.
`default_nettype none

module sss_parser (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_end_of_buffer,
    output sss_pkg::t_step      o_step
);

    logic [31:0] r_pos,   n_pos;
    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_cnt,   n_cnt;
    logic [47:0] r_hdr,   n_hdr;
    logic [31:0] r_ovr,   n_ovr;
    logic        r_pend,  n_pend;
    logic [31:0] r_rem,   n_rem;
    logic [31:0] r_start, n_start;
    logic        r_err,   n_err;

    // Next state and results for the byte at the input
    always_comb begin
        logic [31:0]      v_next;
        logic [31:0]      v_rem_dec;
        logic [2:0]       v_c;
        logic [2:0]       v_c1;
        logic [2:0]       v_ocnt;
        logic [31:0]      v_actual;
        logic             v_sub;
        sss_pkg::t_result v_sub_res;
        sss_pkg::t_result v_stat_res;

        v_next    = r_pos + 32'd1;
        v_rem_dec = r_rem - 32'd1;
        v_c       = (r_cnt >= sss_pkg::HEADER_LEN) ? 3'd0 : r_cnt;
        v_c1      = v_c + 3'd1;
        v_ocnt    = r_cnt + 3'd1;
        v_actual  = r_pend ? r_ovr : {16'd0, i_data_byte, r_hdr[39:32]};
        v_sub     = 1'b0;
        v_sub_res = '0;
        v_sub_res.kind = sss_pkg::KIND_SUBREC;

        n_pos   = v_next;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_hdr   = r_hdr;
        n_ovr   = r_ovr;
        n_pend  = r_pend;
        n_rem   = r_rem;
        n_start = r_start;
        n_err   = r_err;

        if (!r_err) begin
            if (r_phase == sss_pkg::PH_OVERRIDE) begin
                // Collect the 32-bit little-endian override size
                n_ovr = r_ovr | ({24'd0, i_data_byte} << {r_cnt[1:0], 3'b000});
                n_cnt = v_ocnt;
                if (v_ocnt >= sss_pkg::OVERRIDE_LEN) begin
                    n_pend  = 1'b1;
                    n_phase = sss_pkg::PH_HEADER;
                    n_cnt   = 3'd0;
                end
            end else if (r_phase == sss_pkg::PH_PAYLOAD) begin
                // Count down payload bytes; report on the last one
                n_rem = v_rem_dec;
                if (v_rem_dec == 32'd0) begin
                    v_sub                 = 1'b1;
                    v_sub_res.type_code   = r_hdr[31:0];
                    v_sub_res.data_offset = r_start;
                    v_sub_res.data_size   = v_next - r_start;
                    n_phase               = sss_pkg::PH_HEADER;
                end
            end else begin
                // Header byte (unused phase code behaves as header)
                case (v_c)
                    3'd0:    n_hdr = {40'd0, i_data_byte};
                    3'd1:    n_hdr[15:8]  = i_data_byte;
                    3'd2:    n_hdr[23:16] = i_data_byte;
                    3'd3:    n_hdr[31:24] = i_data_byte;
                    3'd4:    n_hdr[39:32] = i_data_byte;
                    default: n_hdr[47:40] = i_data_byte;
                endcase
                n_cnt   = v_c1;
                n_phase = sss_pkg::PH_HEADER;
                if (v_c1 == sss_pkg::HEADER_LEN) begin
                    n_cnt = 3'd0;
                    if (r_hdr[31:0] == sss_pkg::OVERRIDE_TYPE) begin
                        if ({i_data_byte, r_hdr[39:32]} != {13'd0, sss_pkg::OVERRIDE_LEN}) begin
                            n_err = 1'b1;
                        end else begin
                            n_phase = sss_pkg::PH_OVERRIDE;
                            n_ovr   = 32'd0;
                        end
                    end else begin
                        n_pend  = 1'b0;
                        n_start = v_next;
                        if (v_actual == 32'd0) begin
                            v_sub                 = 1'b1;
                            v_sub_res.type_code   = r_hdr[31:0];
                            v_sub_res.data_offset = v_next;
                            v_sub_res.data_size   = 32'd0;
                        end else begin
                            n_rem   = v_actual;
                            n_phase = sss_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
        end

        // Buffer status on the final byte
        v_stat_res             = '0;
        v_stat_res.last_of_run = 1'b1;
        v_stat_res.kind = (n_err || n_phase == sss_pkg::PH_OVERRIDE ||
                           n_phase == sss_pkg::PH_PAYLOAD) ?
                          sss_pkg::KIND_BAD : sss_pkg::KIND_OK;

        o_step.count = {1'b0, v_sub} + {1'b0, i_end_of_buffer};
        o_step.res0  = v_sub ? v_sub_res : v_stat_res;
        o_step.res1  = v_stat_res;

        if (i_end_of_buffer) begin
            n_pos   = 32'd0;
            n_phase = sss_pkg::PH_HEADER;
            n_cnt   = 3'd0;
            n_pend  = 1'b0;
            n_start = 32'd0;
            n_err   = 1'b0;
        end
    end

    // Parser state, updated once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 32'd0;
            r_phase <= sss_pkg::PH_HEADER;
            r_cnt   <= 3'd0;
            r_hdr   <= 48'd0;
            r_ovr   <= 32'd0;
            r_pend  <= 1'b0;
            r_rem   <= 32'd0;
            r_start <= 32'd0;
            r_err   <= 1'b0;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_hdr   <= n_hdr;
            r_ovr   <= n_ovr;
            r_pend  <= n_pend;
            r_rem   <= n_rem;
            r_start <= n_start;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sss_result_fifo.sv =====
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on sss_pkg and sss_out_if.
`default_nettype none

module sss_result_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sss_pkg::t_step i_step,
    output logic                o_room,
    sss_out_if.source           o_out
);

    localparam int PW = sss_pkg::FIFO_PTR_W;

    sss_pkg::t_result r_mem [sss_pkg::FIFO_DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [PW:0]      r_cnt, n_cnt;
    logic [1:0]       w_npush;
    logic             w_pop;
    logic [PW-1:0]    w_wp1;

    assign w_npush = i_push ? i_step.count : 2'd0;
    assign w_pop   = o_out.valid && o_out.ready;
    assign w_wp1   = r_wp + PW'(1);
    assign o_room  = r_cnt <= (PW+1)'(sss_pkg::FIFO_DEPTH - 2);

    // Pointer and fill bookkeeping
    always_comb begin
        n_wp  = r_wp + PW'(w_npush);
        n_rp  = w_pop ? r_rp + PW'(1) : r_rp;
        n_cnt = r_cnt + (PW+1)'(w_npush) - (PW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Result storage
    always_ff @(posedge i_clk) begin
        if (w_npush != 2'd0) begin
            r_mem[r_wp] <= i_step.res0;
        end
        if (w_npush == 2'd2) begin
            r_mem[w_wp1] <= i_step.res1;
        end
    end

    // Head of queue drives the output channel
    assign o_out.valid       = r_cnt != '0;
    assign o_out.kind        = r_mem[r_rp].kind;
    assign o_out.type_code   = r_mem[r_rp].type_code;
    assign o_out.data_offset = r_mem[r_rp].data_offset;
    assign o_out.data_size   = r_mem[r_rp].data_size;
    assign o_out.last_of_run = r_mem[r_rp].last_of_run;

endmodule

`default_nettype wire
